/* hw/rtl/lfpwm_pkg.sv */
// ============================================================================
// lfpwm_pkg
// Types and constants for the LED fade / PWM shift-frame driver.
// ============================================================================
package lfpwm_pkg;

    typedef logic [7:0]  level_t;
    typedef logic [4:0]  led_idx_t;
    typedef logic [22:0] frame_t;

    // request kinds
    localparam logic KIND_SET  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam level_t PWM_STEP_RESET  = 8'd9;
    localparam level_t PWM_PHASE_RESET = 8'd3;

    // LEDs that appear in the frame, in shift order (first 15 above the gates,
    // last four below them)
    localparam int FRAME_LEDS  = 19;
    localparam int UPPER_LEDS  = 15;
    localparam int FRAME_WIDTH = 23;

    localparam led_idx_t FRAME_ORDER [FRAME_LEDS] = '{
        5'd12, 5'd17, 5'd16, 5'd15, 5'd14, 5'd13, 5'd18, 5'd4, 5'd5, 5'd6,
        5'd7,  5'd8,  5'd9,  5'd10, 5'd11, 5'd3,  5'd2,  5'd1, 5'd0
    };

endpackage

/* hw/rtl/led_fade_pwm_shift_frame.sv */
// ============================================================================
// led_fade_pwm_shift_frame
// Per-LED fade towards target levels, PWM phase and 23-bit shift frame.
// ============================================================================
//
//  channel   handshake            payload
//  -------   ------------------   ---------------------------------------------
//  in        in_valid / in_stall  kind, led_index, level, rise_now, gate_*
//  out       out_valid/out_stall  frame_bits, phase_now
//  cfg       cfg_valid/cfg_ready  cfg_data (pwm_step)
//
//  One request per cycle while in_stall is low: input register, then all levels,
//  the phase and the frame are worked out in one pass into the state and output
//  registers. A tick goes through the input register, then the output register.
//  Reset clears levels and targets, sets phase 3, step 9; cfg is always ready.
//  A tick waiting in the input register holds in_stall while the output
//  register is full and stalled; set-target requests never wait.
//
module led_fade_pwm_shift_frame #(
    parameter int LED_COUNT = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                kind,
    input  lfpwm_pkg::led_idx_t led_index,
    input  lfpwm_pkg::level_t   level,
    input  logic                rise_now,
    input  logic                gate_attack_end,
    input  logic                gate_decay_end,
    input  logic                gate_release_start,
    input  logic                gate_release_end,
    output logic                out_valid,
    input  logic                out_stall,
    output lfpwm_pkg::frame_t   frame_bits,
    output lfpwm_pkg::level_t   phase_now,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  lfpwm_pkg::level_t   cfg_data
);
    import lfpwm_pkg::*;

    localparam logic [5:0] LED_COUNT_W = 6'(LED_COUNT);

    // input register
    logic     s1_valid_reg;
    logic     s1_kind_reg;
    led_idx_t s1_idx_reg;
    level_t   s1_level_reg;
    logic     s1_rise_reg;
    logic [3:0] s1_gate_reg;   // attack_end, decay_end, release_start, release_end

    // state
    level_t cur_reg [LED_COUNT];
    level_t tgt_reg [LED_COUNT];
    level_t cur_next [LED_COUNT];
    level_t tgt_next [LED_COUNT];
    level_t pwm_phase_reg;
    level_t pwm_phase_next;
    logic   tick_phase_reg;
    level_t pwm_step_reg;

    // output register
    logic   out_valid_reg;
    frame_t frame_reg;
    frame_t frame_next;
    level_t phase_out_reg;

    logic out_free;
    logic s1_adv;
    logic s1_tick;
    logic s1_set_hit;
    logic do_step;

    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_tick    = (s1_kind_reg == KIND_TICK);
    assign s1_adv     = s1_valid_reg && (!s1_tick || out_free);
    assign s1_set_hit = s1_adv && !s1_tick && ({1'b0, s1_idx_reg} < LED_COUNT_W);
    // levels step on the tick that brings the phase bit back to 0
    assign do_step    = s1_adv && s1_tick && tick_phase_reg;
    assign in_stall   = s1_valid_reg && !s1_adv;
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        for (int i = 0; i < LED_COUNT; i++)
        begin
            cur_next[i] = cur_reg[i];
            tgt_next[i] = tgt_reg[i];
            if (s1_set_hit && (s1_idx_reg == 5'(i)))
            begin
                tgt_next[i] = s1_level_reg;
                if (s1_rise_reg && (cur_reg[i] < s1_level_reg))
                begin
                    cur_next[i] = s1_level_reg;
                end
            end
            else if (do_step)
            begin
                if (tgt_reg[i] > cur_reg[i])
                begin
                    cur_next[i] = cur_reg[i] + 8'd1;
                end
                else if (tgt_reg[i] < cur_reg[i])
                begin
                    cur_next[i] = cur_reg[i] - 8'd1;
                end
            end
        end
    end

    assign pwm_phase_next = pwm_phase_reg + pwm_step_reg;

    always_comb
    begin
        frame_next = '0;
        for (int k = 0; k < UPPER_LEDS; k++)
        begin
            frame_next[FRAME_WIDTH - 1 - k] = cur_next[FRAME_ORDER[k]] > pwm_phase_next;
        end
        frame_next[7] = ~s1_gate_reg[2];
        frame_next[6] = ~s1_gate_reg[1];
        frame_next[5] = ~s1_gate_reg[0];
        for (int k = UPPER_LEDS; k < FRAME_LEDS; k++)
        begin
            frame_next[FRAME_LEDS - k] = cur_next[FRAME_ORDER[k]] > pwm_phase_next;
        end
        frame_next[0] = ~s1_gate_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            pwm_phase_reg  <= PWM_PHASE_RESET;
            tick_phase_reg <= 1'b0;
            pwm_step_reg   <= PWM_STEP_RESET;
            for (int i = 0; i < LED_COUNT; i++)
            begin
                cur_reg[i] <= '0;
                tgt_reg[i] <= '0;
            end
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (cfg_valid && cfg_ready)
            begin
                pwm_step_reg <= cfg_data;
            end
            for (int i = 0; i < LED_COUNT; i++)
            begin
                cur_reg[i] <= cur_next[i];
                tgt_reg[i] <= tgt_next[i];
            end
            if (s1_adv && s1_tick)
            begin
                tick_phase_reg <= ~tick_phase_reg;
                pwm_phase_reg  <= pwm_phase_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_kind_reg  <= kind;
            s1_idx_reg   <= led_index;
            s1_level_reg <= level;
            s1_rise_reg  <= rise_now;
            s1_gate_reg  <= {gate_attack_end, gate_decay_end,
                             gate_release_start, gate_release_end};
        end
        if (s1_adv && s1_tick)
        begin
            frame_reg     <= frame_next;
            phase_out_reg <= pwm_phase_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_bits = frame_reg;
    assign phase_now  = phase_out_reg;

`ifndef SYNTH
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty input register");

    a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_tick) |=> (out_valid && (phase_now == pwm_phase_reg)))
        else $error("tick did not present its frame and phase");

    a_phase_bit_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_adv && s1_tick) |=> ($stable(tick_phase_reg) && $stable(pwm_phase_reg)))
        else $error("tick or PWM phase moved without a tick");
`endif

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the LED fade / PWM shift-frame driver. A clocked
// driver feeds requests from a queue, and a clocked monitor checks each frame
// against a predicted copy of the LED levels, the phase and the step.
// Both sides idle in random bursts until the last phase. One long output hold-off fills the block.
// ============================================================================
module testbench;

    import lfpwm_pkg::*;

    localparam int LEDS       = 20;
    localparam int WATCHDOG   = 1000;
    localparam int SETTLE     = 4;
    localparam int HOLD_LONG  = 200;
    localparam int PHASE_REQS = 220;

    // LEDs in shift order: first 15 above the gate bits, last four below them
    localparam int SHIFT_ORDER [19] = '{
        12, 17, 16, 15, 14, 13, 18, 4, 5, 6, 7, 8, 9, 10, 11, 3, 2, 1, 0
    };

    typedef struct {
        logic     kind;
        led_idx_t led;
        level_t   level;
        logic     rise;
        logic     g_attack;
        logic     g_decay;
        logic     g_rel_start;
        logic     g_rel_end;
    } request_t;

    typedef struct {
        frame_t frame;
        level_t phase;
    } frame_rec_t;

    logic     clk                = 1'b0;
    logic     rst_n              = 1'b0;
    logic     in_valid           = 1'b0;
    logic     in_stall;
    logic     kind               = KIND_SET;
    led_idx_t led_index          = '0;
    level_t   level              = '0;
    logic     rise_now           = 1'b0;
    logic     gate_attack_end    = 1'b0;
    logic     gate_decay_end     = 1'b0;
    logic     gate_release_start = 1'b0;
    logic     gate_release_end   = 1'b0;
    logic     out_valid;
    logic     out_stall          = 1'b0;
    frame_t   frame_bits;
    level_t   phase_now;
    logic     cfg_valid          = 1'b0;
    logic     cfg_ready;
    level_t   cfg_data           = '0;

    // predicted block state
    level_t lvl_now  [LEDS];
    level_t lvl_goal [LEDS];
    level_t phase_acc;
    logic   tick_odd;
    level_t step_cfg;

    request_t   pending [$];
    frame_rec_t frames_due [$];
    request_t   offered;

    int   fault_count  = 0;
    int   in_gap       = 0;
    int   out_gap      = 0;
    int   out_hold     = 0;
    int   squeeze_seq  = 0;
    int   squeeze_seen = 0;
    int   idle_cycles  = 0;
    logic calm         = 1'b0;

    led_fade_pwm_shift_frame #(.LED_COUNT(LEDS)) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .kind               (kind),
        .led_index          (led_index),
        .level              (level),
        .rise_now           (rise_now),
        .gate_attack_end    (gate_attack_end),
        .gate_decay_end     (gate_decay_end),
        .gate_release_start (gate_release_start),
        .gate_release_end   (gate_release_end),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .frame_bits         (frame_bits),
        .phase_now          (phase_now),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Updates the predicted state for one accepted request and queues the
    // frame a tick produces.
    function automatic void apply_request(request_t r);
        frame_rec_t rec;
        int         i;
        if (r.kind == KIND_SET)
        begin
            if (r.led < LEDS)
            begin
                lvl_goal[r.led] = r.level;
                if (r.rise && lvl_now[r.led] < r.level)
                    lvl_now[r.led] = r.level;
            end
            return;
        end
        tick_odd = ~tick_odd;
        if (!tick_odd)
        begin
            for (i = 0; i < LEDS; i++)
            begin
                if (lvl_goal[i] > lvl_now[i])
                    lvl_now[i] = lvl_now[i] + 8'd1;
                else if (lvl_goal[i] < lvl_now[i])
                    lvl_now[i] = lvl_now[i] - 8'd1;
            end
        end
        phase_acc = phase_acc + step_cfg;
        rec.frame = '0;
        for (i = 0; i < 15; i++)
            rec.frame[22 - i] = lvl_now[SHIFT_ORDER[i]] > phase_acc;
        for (i = 15; i < 19; i++)
            rec.frame[19 - i] = lvl_now[SHIFT_ORDER[i]] > phase_acc;
        rec.frame[7] = ~r.g_decay;
        rec.frame[6] = ~r.g_rel_start;
        rec.frame[5] = ~r.g_rel_end;
        rec.frame[0] = ~r.g_attack;
        rec.phase    = phase_acc;
        frames_due.push_back(rec);
    endfunction

    // Unused fields are filled at random so that ignoring them is checked.
    function automatic request_t set_req(int led, int lvl, bit rise);
        request_t r;
        r.kind        = KIND_SET;
        r.led         = led_idx_t'(led);
        r.level       = level_t'(lvl);
        r.rise        = rise;
        r.g_attack    = 1'($urandom_range(0, 1));
        r.g_decay     = 1'($urandom_range(0, 1));
        r.g_rel_start = 1'($urandom_range(0, 1));
        r.g_rel_end   = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // gates: {attack_end, decay_end, release_start, release_end}
    function automatic request_t tick_req(logic [3:0] gates);
        request_t r;
        r.kind        = KIND_TICK;
        r.led         = led_idx_t'($urandom_range(0, 31));
        r.level       = level_t'($urandom_range(0, 255));
        r.rise        = 1'($urandom_range(0, 1));
        r.g_attack    = gates[3];
        r.g_decay     = gates[2];
        r.g_rel_start = gates[1];
        r.g_rel_end   = gates[0];
        return r;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                apply_request(offered);
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 7) == 0)
                begin
                    in_gap = $urandom_range(1, 9) - 1;
                    in_valid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    offered = pending.pop_front();
                    kind               <= offered.kind;
                    led_index          <= offered.led;
                    level              <= offered.level;
                    rise_now           <= offered.rise;
                    gate_attack_end    <= offered.g_attack;
                    gate_decay_end     <= offered.g_decay;
                    gate_release_start <= offered.g_rel_start;
                    gate_release_end   <= offered.g_rel_end;
                    in_valid           <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and output stall
    always @(posedge clk)
    begin
        frame_rec_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (frames_due.size() == 0)
                begin
                    if (fault_count < 10)
                        $display("unexpected frame %06h phase %0d", frame_bits, phase_now);
                    fault_count++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (frame_bits !== want.frame || phase_now !== want.phase)
                    begin
                        if (fault_count < 10)
                            $display("frame mismatch: expected %06h/%0d, got %06h/%0d",
                                     want.frame, want.phase, frame_bits, phase_now);
                        fault_count++;
                    end
                end
            end
            if (squeeze_seen != squeeze_seq)
            begin
                squeeze_seen = squeeze_seq;
                out_hold     = HOLD_LONG;
            end
            if (out_hold > 0)
            begin
                out_hold--;
                out_stall <= 1'b1;
            end
            else if (out_gap > 0)
            begin
                out_gap--;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_gap = $urandom_range(1, 9) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic drain();
        while (pending.size() != 0 || in_valid || frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // writes the step, then a batch of random requests
    task automatic run_phase(level_t step, int count, bit squeeze);
        int       n;
        int       pick;
        request_t r;
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= step;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        step_cfg = step;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 45)
                r = tick_req(4'($urandom_range(0, 15)));
            else
            begin
                pick = $urandom_range(0, 5);
                r = set_req(($urandom_range(0, 7) == 0) ? $urandom_range(LEDS, 31)
                                                        : $urandom_range(0, LEDS - 1),
                            (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(0, 255),
                            1'($urandom_range(0, 1)));
            end
            pending.push_back(r);
        end
        if (squeeze)
            squeeze_seq++;
        drain();
    endtask

    initial
    begin
        int k;
        for (k = 0; k < LEDS; k++)
        begin
            lvl_now[k]  = '0;
            lvl_goal[k] = '0;
        end
        phase_acc = PWM_PHASE_RESET;
        tick_odd  = 1'b0;
        step_cfg  = PWM_STEP_RESET;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed requests at the reset step: first tick does not fade
        pending.push_back(tick_req(4'b0000));
        pending.push_back(set_req(0, 255, 1));
        pending.push_back(set_req(19, 200, 0));
        pending.push_back(set_req(31, 255, 1));   // out of range, ignored
        pending.push_back(set_req(20, 77, 1));    // out of range, ignored
        pending.push_back(tick_req(4'b1111));
        pending.push_back(set_req(5, 128, 1));
        pending.push_back(set_req(5, 100, 1));    // already above target, no jump
        pending.push_back(set_req(12, 1, 1));
        pending.push_back(tick_req(4'b1010));
        pending.push_back(tick_req(4'b0101));
        pending.push_back(set_req(18, 255, 1));
        pending.push_back(set_req(0, 0, 0));      // fades down one step per two ticks
        pending.push_back(set_req(17, 0, 1));
        pending.push_back(tick_req(4'b1000));
        pending.push_back(tick_req(4'b0100));
        pending.push_back(tick_req(4'b0010));
        pending.push_back(tick_req(4'b0001));
        pending.push_back(set_req(3, 2, 0));
        pending.push_back(set_req(11, 254, 1));
        pending.push_back(tick_req(4'b0110));
        pending.push_back(tick_req(4'b1001));
        drain();

        run_phase(8'd0, PHASE_REQS, 1'b0);
        run_phase(8'd255, PHASE_REQS, 1'b0);
        run_phase(8'd128, PHASE_REQS, 1'b1);
        run_phase(8'd1, PHASE_REQS, 1'b0);
        run_phase(level_t'($urandom_range(2, 254)), PHASE_REQS, 1'b0);
        calm = 1'b1;
        run_phase(PWM_STEP_RESET, PHASE_REQS, 1'b0);

        fault_count += frames_due.size();
        if (fault_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/lfpwm_pkg.sv
hw/rtl/led_fade_pwm_shift_frame.sv
tb/sv/testbench.sv
